>>> sv/pnco_pkg.sv
package pnco_pkg;

   localparam int COMP_W = 6;
   localparam int SQ_W   = 12;
   localparam int DIST_W = 14;
   localparam int POS_W  = 9;
   localparam int OUT_W  = 8;

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_RESTART = 2'd1,
      KIND_NEXT    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic init;
      logic issue;
   } search_ctl_type;

endpackage

>>> sv/pnco_store.sv
module pnco_store
   import pnco_pkg::*;
#(
   parameter int NUM_COLORS = 256,
   parameter int IDX_W      = 8
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_addr,
   input  logic             color_we,
   input  logic [IDX_W-1:0] color_waddr,
   input  color_type        color_wdata,
   input  logic             mark_we,
   input  logic [IDX_W-1:0] mark_waddr,
   input  logic             mark_wdata,
   output color_type        color_rdata,
   output logic             mark_rdata
);

   color_type color_mem_ff [NUM_COLORS];
   logic      mark_mem_ff  [NUM_COLORS];
   color_type color_rd_ff;
   logic      mark_rd_ff;

   always_ff @(posedge clock) begin
      if (color_we) begin
         color_mem_ff[color_waddr] <= color_wdata;
      end
      color_rd_ff <= color_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem_ff[mark_waddr] <= mark_wdata;
      end
      mark_rd_ff <= mark_mem_ff[rd_addr];
   end

   assign color_rdata = color_rd_ff;
   assign mark_rdata  = mark_rd_ff;

endmodule

>>> sv/pnco_search.sv
module pnco_search
   import pnco_pkg::*;
#(
   parameter int IDX_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  search_ctl_type   ctl,
   input  logic [IDX_W-1:0] issue_index,
   input  color_type        rd_color,
   input  logic             rd_used,
   input  color_type        ref_color,
   output logic             pending,
   output logic             found,
   output logic [IDX_W-1:0] best_index,
   output color_type        best_color
);

   function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                               input logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   logic             s1_valid_ff;
   logic [IDX_W-1:0] s1_index_ff;
   logic             s2_valid_ff;
   logic [IDX_W-1:0] s2_index_ff;
   color_type        s2_color_ff;
   logic [SQ_W-1:0]  sq_r_ff, sq_g_ff, sq_b_ff;
   logic             found_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic [IDX_W-1:0] best_index_ff;
   color_type        best_color_ff;
   logic [DIST_W-1:0] dist_sum;
   logic             take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.issue;
         s2_valid_ff <= s1_valid_ff && !rd_used;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff <= issue_index;
      s2_index_ff <= s1_index_ff;
      s2_color_ff <= rd_color;
      sq_r_ff     <= sq_diff(rd_color.red, ref_color.red);
      sq_g_ff     <= sq_diff(rd_color.green, ref_color.green);
      sq_b_ff     <= sq_diff(rd_color.blue, ref_color.blue);
   end

   assign dist_sum = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
   assign take = s2_valid_ff && (!found_ff || (dist_sum < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_dist_ff  <= dist_sum;
         best_index_ff <= s2_index_ff;
         best_color_ff <= s2_color_ff;
      end
   end

   assign pending    = s1_valid_ff || s2_valid_ff;
   assign found      = found_ff;
   assign best_index = best_index_ff;
   assign best_color = best_color_ff;

endmodule

>>> sv/palette_nearest_chain_order.sv
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ---------------------------
// request   req_kind req_entry_index req_red/green/blue   start high, busy low
// result    rsp_color_index rsp_position rsp_exhausted   rsp_valid, one cycle
//
// A load or an ignored kind leaves busy low.
// A next item makes one color memory read per entry, then drains the distance
// pipeline and posts the result.
// A restart item clears the used-mark memory one entry a cycle. The same
// clearing pass follows reset.
// The receiver cannot stall; each result shows for exactly one cycle.
module palette_nearest_chain_order
   import pnco_pkg::*;
#(
   parameter int NUM_COLORS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_kind,
   input  logic [7:0]   req_entry_index,
   input  logic [5:0]   req_red,
   input  logic [5:0]   req_green,
   input  logic [5:0]   req_blue,
   output logic         rsp_valid,
   output logic [7:0]   rsp_color_index,
   output logic [7:0]   rsp_position,
   output logic         rsp_exhausted
);

   localparam int IDX_W = $clog2(NUM_COLORS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_COLORS - 1);
   localparam logic [10:0] NUM_LIMIT = 11'(NUM_COLORS);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   color_type        ref_ff, ref_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_index_ff, rsp_index_in;
   logic [OUT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic             rsp_exh_ff, rsp_exh_in;

   logic             color_we;
   color_type        color_wdata;
   logic             mark_we;
   logic [IDX_W-1:0] mark_waddr;
   logic             mark_wdata;
   color_type        color_rdata;
   logic             mark_rdata;
   search_ctl_type   ctl;
   logic             pending;
   logic             found;
   logic [IDX_W-1:0] best_index;
   color_type        best_color;
   logic             load_in_range;

   assign color_wdata   = '{red: req_red, green: req_green, blue: req_blue};
   assign load_in_range = {3'b000, req_entry_index} < NUM_LIMIT;

   pnco_store #(
      .NUM_COLORS (NUM_COLORS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock       (clock),
      .rd_addr     (addr_ff),
      .color_we    (color_we),
      .color_waddr (IDX_W'(req_entry_index)),
      .color_wdata (color_wdata),
      .mark_we     (mark_we),
      .mark_waddr  (mark_waddr),
      .mark_wdata  (mark_wdata),
      .color_rdata (color_rdata),
      .mark_rdata  (mark_rdata)
   );

   pnco_search #(
      .IDX_W (IDX_W)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .issue_index (addr_ff),
      .rd_color    (color_rdata),
      .rd_used     (mark_rdata),
      .ref_color   (ref_ff),
      .pending     (pending),
      .found       (found),
      .best_index  (best_index),
      .best_color  (best_color)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         ref_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         ref_ff       <= ref_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_exh_ff   <= rsp_exh_in;
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      ref_in       = ref_ff;
      pos_in       = pos_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_exh_in   = rsp_exh_ff;
      color_we     = 1'b0;
      mark_we      = 1'b0;
      mark_waddr   = addr_ff;
      mark_wdata   = 1'b0;
      ctl          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mark_we = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (kind_type'(req_kind))
                  KIND_LOAD: begin
                     color_we = load_in_range;
                  end
                  KIND_RESTART: begin
                     ref_in   = '0;
                     pos_in   = '0;
                     addr_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  KIND_NEXT: begin
                     ctl.init = 1'b1;
                     addr_in  = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            ctl.issue = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!pending) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (found) begin
                  rsp_index_in = OUT_W'(best_index);
                  rsp_pos_in   = pos_ff[OUT_W-1:0];
                  rsp_exh_in   = 1'b0;
                  mark_we      = 1'b1;
                  mark_waddr   = best_index;
                  mark_wdata   = 1'b1;
                  ref_in       = best_color;
                  pos_in       = pos_ff + 1'b1;
               end else begin
                  rsp_index_in = '0;
                  rsp_pos_in   = '0;
                  rsp_exh_in   = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_index_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_exhausted   = rsp_exh_ff;

   a_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DRAIN))
      else $error("result strobe without a finished scan");

   a_next_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_NEXT) |=> (state_ff == ST_SCAN))
      else $error("next item did not start a scan");

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !color_we)
      else $error("color write while busy");

   a_exhausted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_exhausted) |-> (rsp_color_index == 8'd0 && rsp_position == 8'd0))
      else $error("exhausted result carries nonzero fields");

endmodule
